// File: rtl/banded_viterbi_path_decoder_macros.svh
// Assertion macros for the banded Viterbi path decoder checker.
// No dependencies.
`ifndef BANDED_VITERBI_PATH_DECODER_MACROS_SVH
`define BANDED_VITERBI_PATH_DECODER_MACROS_SVH

// Implication checked only out of reset.
`define BVPD_ASSERT_IMP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define BVPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/bvpd_pkg.sv
// Package for the banded Viterbi path decoder: widths, codes, FSM type,
// emission log table builder and score saturation. No dependencies.
package bvpd_pkg;

  localparam int BINS_MAX_DEF      = 64;
  localparam int ROWS_MAX_DEF      = 64;
  localparam int HALF_BAND_MAX_DEF = 2;

  localparam int PROB_W     = 11;
  localparam int EM_W       = 15;
  localparam int SCORE_W    = 24;
  localparam int WEIGHT_W   = 15;
  localparam int NUM_W      = 7;
  localparam int HB_W       = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;
  localparam int BIN_OUT_W  = 6;
  localparam int NUM_WEIGHTS = 5;
  localparam int BEST_W     = SCORE_W + 1;
  localparam int SUM_W      = SCORE_W + 3;

  localparam logic [63:0] LN2_Q30 = 64'd744261118;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_BINS    = 3'd0,
    REG_NUM_ROWS    = 3'd1,
    REG_HALF_BAND   = 3'd2,
    REG_WEIGHT_M2   = 3'd3,
    REG_WEIGHT_M1   = 3'd4,
    REG_WEIGHT_ZERO = 3'd5,
    REG_WEIGHT_P1   = 3'd6,
    REG_WEIGHT_P2   = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_WRITE,
    ST_PRE,
    ST_BT_RD,
    ST_BT_WAIT,
    ST_OUT_RD,
    ST_OUT_LD
  } state_t;

  typedef logic signed [EM_W-1:0] em_rom_t [2**PROB_W];

  // log2 in Q20 by repeated squaring of the Q1.30 mantissa
  function automatic logic [31:0] log2_q20(input logic [31:0] x);
    logic [4:0]  e;
    logic [63:0] m;
    logic [19:0] frac;
    e = '0;
    for (int i = 1; i < 32; i++) begin
      if ((x >> i) != 0) e = 5'(i);
    end
    m = {32'd0, x} << (30 - e);
    frac = '0;
    for (int i = 0; i < 20; i++) begin
      m = (m * m) >> 30;
      frac = {frac[18:0], 1'b0};
      if (m >= 64'h8000_0000) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    return {7'd0, e, frac};
  endfunction

  function automatic logic signed [EM_W-1:0] emission_log(input logic [PROB_W-1:0] p);
    logic [31:0]        a;
    logic signed [33:0] d;
    logic [33:0]        mag;
    logic [63:0]        q;
    a   = 32'(p) * 32'd100 + 32'd1024;
    d   = signed'({2'b00, log2_q20(a)}) - signed'({2'b00, log2_q20(32'd102400)});
    mag = d[33] ? 34'(-d) : 34'(d);
    q   = (64'(mag) * LN2_Q30 + (64'd1 << 38)) >> 39;
    return d[33] ? -EM_W'(q) : EM_W'(q);
  endfunction

  function automatic em_rom_t em_rom_build();
    em_rom_t rom;
    for (int i = 0; i < 2**PROB_W; i++) begin
      rom[i] = emission_log(PROB_W'(i));
    end
    return rom;
  endfunction

  function automatic logic signed [SCORE_W-1:0] sat_score(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(signed'({1'b0, {(SCORE_W-1){1'b1}}}));
    lo = SUM_W'(signed'({1'b1, {(SCORE_W-1){1'b0}}}));
    if (v > hi) return hi[SCORE_W-1:0];
    if (v < lo) return lo[SCORE_W-1:0];
    return v[SCORE_W-1:0];
  endfunction

endpackage

// File: rtl/bvpd_if.sv
// Request channel interfaces of the banded Viterbi path decoder.
// Depends on bvpd_pkg.
interface bvpd_in_if;
  logic                         valid;
  logic                         ready;
  logic [bvpd_pkg::PROB_W-1:0]  cell_prob;
  logic                         map_end;
  modport source (output valid, cell_prob, map_end, input ready);
  modport sink   (input valid, cell_prob, map_end, output ready);
endinterface

interface bvpd_out_if;
  logic                           valid;
  logic                           ready;
  logic [bvpd_pkg::BIN_OUT_W-1:0] bin_index;
  logic                           path_last;
  modport source (output valid, bin_index, path_last, input ready);
  modport sink   (input valid, bin_index, path_last, output ready);
endinterface

// File: rtl/bvpd_ram.sv
// Generic simple dual port RAM, one write and one registered read port.
// Read returns the old data on a same-address write. No dependencies.
module bvpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

// File: rtl/banded_viterbi_path_decoder.sv
// Banded Viterbi path decoder top level. Depends on bvpd_pkg, bvpd_if
// and bvpd_ram.
//
// Takes a probability map one cell per request, row by row, and at the end of
// the map returns the best path as one bin per row, first row first. A cell
// passes through accept, band compare, then score and pointer write; after
// each completed row the previous-row window is reloaded from the score RAM.
// At map end the backtrack runs through the pointer RAM row by row, then each
// result is read out. Scores live in a 2*2**$clog2(BINS_MAX)-entry ping-pong
// RAM, back pointers in a ROWS_MAX*BINS_MAX-entry RAM; neither needs clearing
// after reset.
module banded_viterbi_path_decoder #(
  parameter int BINS_MAX      = bvpd_pkg::BINS_MAX_DEF,
  parameter int ROWS_MAX      = bvpd_pkg::ROWS_MAX_DEF,
  parameter int HALF_BAND_MAX = bvpd_pkg::HALF_BAND_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bvpd_in_if.sink                         in_chan,
  bvpd_out_if.source                      out_chan,
  input  logic                            cfg_we,
  input  logic [bvpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bvpd_pkg::CFG_DATA_W-1:0] cfg_data
);
  localparam int BW       = $clog2(BINS_MAX);
  localparam int RW       = $clog2(ROWS_MAX);
  localparam int NBW      = BW + 1;
  localparam int NRW      = RW + 1;
  localparam int WIN      = 2 * HALF_BAND_MAX + 1;
  localparam int SA_W     = BW + 1;
  localparam int BP_DEPTH = ROWS_MAX * BINS_MAX;
  localparam int BPA_W    = $clog2(BP_DEPTH);
  localparam int PJW      = $clog2(HALF_BAND_MAX + 2);

  localparam bvpd_pkg::em_rom_t EM_ROM = bvpd_pkg::em_rom_build();

  // configuration
  logic [bvpd_pkg::NUM_W-1:0]           num_bins_r, num_rows_r;
  logic [bvpd_pkg::HB_W-1:0]            half_band_r;
  logic signed [bvpd_pkg::WEIGHT_W-1:0] weight_r [bvpd_pkg::NUM_WEIGHTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_bins_r  <= bvpd_pkg::NUM_W'(64);
      num_rows_r  <= bvpd_pkg::NUM_W'(64);
      half_band_r <= bvpd_pkg::HB_W'(1);
      for (int i = 0; i < bvpd_pkg::NUM_WEIGHTS; i++) weight_r[i] <= '0;
    end else if (cfg_we) begin
      unique case (bvpd_pkg::cfg_reg_t'(cfg_index))
        bvpd_pkg::REG_NUM_BINS:    num_bins_r  <= cfg_data[bvpd_pkg::NUM_W-1:0];
        bvpd_pkg::REG_NUM_ROWS:    num_rows_r  <= cfg_data[bvpd_pkg::NUM_W-1:0];
        bvpd_pkg::REG_HALF_BAND:   half_band_r <= cfg_data[bvpd_pkg::HB_W-1:0];
        bvpd_pkg::REG_WEIGHT_M2:   weight_r[0] <= cfg_data;
        bvpd_pkg::REG_WEIGHT_M1:   weight_r[1] <= cfg_data;
        bvpd_pkg::REG_WEIGHT_ZERO: weight_r[2] <= cfg_data;
        bvpd_pkg::REG_WEIGHT_P1:   weight_r[3] <= cfg_data;
        bvpd_pkg::REG_WEIGHT_P2:   weight_r[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [NBW-1:0]            nb_eff;
  logic [NRW-1:0]            nr_eff;
  logic [bvpd_pkg::HB_W-1:0] hb_eff;

  assign nb_eff = (num_bins_r == '0) ? NBW'(1) :
                  ((int'(num_bins_r) > BINS_MAX) ? NBW'(BINS_MAX) : NBW'(num_bins_r));
  assign nr_eff = (num_rows_r == '0) ? NRW'(1) :
                  ((int'(num_rows_r) > ROWS_MAX) ? NRW'(ROWS_MAX) : NRW'(num_rows_r));
  assign hb_eff = (int'(half_band_r) > HALF_BAND_MAX) ? bvpd_pkg::HB_W'(HALF_BAND_MAX)
                                                      : half_band_r;

  // state and datapath registers
  bvpd_pkg::state_t st_r, st_nxt;
  logic [BW-1:0]    col_r;
  logic [RW-1:0]    row_r, k_r, lastrow_r;
  logic             bank_r, end_r;
  logic [PJW-1:0]   pj_r;
  logic [BW-1:0]    bt_b_r, best_col_r, run_col_r;
  logic signed [bvpd_pkg::EM_W-1:0]    em_r;
  logic signed [bvpd_pkg::BEST_W-1:0]  best_r;
  logic signed [bvpd_pkg::SCORE_W-1:0] run_best_r, nxt_r;
  logic signed [bvpd_pkg::SCORE_W-1:0] win_r [WIN];
  logic                               out_valid_r, out_last_r;
  logic [bvpd_pkg::BIN_OUT_W-1:0]     out_bin_r;

  // memories
  logic                 s_we, s_re;
  logic [SA_W-1:0]      s_waddr, s_raddr;
  logic [bvpd_pkg::SCORE_W-1:0] s_wdata, s_rdata;
  logic                 b_we, b_re;
  logic [BPA_W-1:0]     b_waddr, b_raddr;
  logic [BW-1:0]        b_wdata, b_rdata;

  bvpd_ram #(.WIDTH(bvpd_pkg::SCORE_W), .DEPTH(2**SA_W)) u_score_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .re(s_re), .raddr(s_raddr), .rdata(s_rdata)
  );

  bvpd_ram #(.WIDTH(BW), .DEPTH(BP_DEPTH)) u_bp_ram (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .re(b_re), .raddr(b_raddr), .rdata(b_rdata)
  );

  logic in_fire, out_fire, out_load;
  logic row_done, last_row, map_done, score_better;
  logic signed [bvpd_pkg::SCORE_W-1:0] score;
  logic signed [bvpd_pkg::BEST_W-1:0]  best_v;
  logic [BW-1:0]                       best_c, final_b;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_fire = out_chan.valid && out_chan.ready;
  assign out_load = (st_r == bvpd_pkg::ST_OUT_LD) && (!out_valid_r || out_fire);

  assign row_done = (NBW'(col_r) + NBW'(1)) >= nb_eff;
  assign last_row = (NRW'(row_r) + NRW'(1)) >= nr_eff;
  assign map_done = end_r || (row_done && last_row);

  // band compare, lowest predecessor column wins ties
  always_comb begin
    int   w;
    int   pc;
    logic found;
    logic signed [bvpd_pkg::BEST_W-1:0] v;
    found  = 1'b0;
    best_v = '0;
    best_c = col_r;
    for (int k = 0; k < WIN; k++) begin
      w  = k - HALF_BAND_MAX;
      pc = int'(col_r) + w;
      v  = bvpd_pkg::BEST_W'(win_r[k]) + bvpd_pkg::BEST_W'(weight_r[w + 2]);
      if (w >= -int'(hb_eff) && w <= int'(hb_eff) &&
          (w == 0 || (pc >= 0 && pc < int'(nb_eff)))) begin
        if (!found || v > best_v) begin
          best_v = v;
          best_c = BW'(pc);
          found  = 1'b1;
        end
      end
    end
  end

  assign score = (row_r == '0)
    ? bvpd_pkg::sat_score(bvpd_pkg::SUM_W'(em_r))
    : bvpd_pkg::sat_score(bvpd_pkg::SUM_W'(best_r) + bvpd_pkg::SUM_W'(em_r));
  assign score_better = (col_r == '0) || (score > run_best_r);
  assign final_b      = score_better ? col_r : run_col_r;

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      bvpd_pkg::ST_IDLE:    if (in_fire) st_nxt = bvpd_pkg::ST_CALC;
      bvpd_pkg::ST_CALC:    st_nxt = bvpd_pkg::ST_WRITE;
      bvpd_pkg::ST_WRITE: begin
        if (map_done)      st_nxt = bvpd_pkg::ST_BT_RD;
        else if (row_done) st_nxt = bvpd_pkg::ST_PRE;
        else               st_nxt = bvpd_pkg::ST_IDLE;
      end
      bvpd_pkg::ST_PRE:     if (int'(pj_r) == HALF_BAND_MAX + 1) st_nxt = bvpd_pkg::ST_IDLE;
      bvpd_pkg::ST_BT_RD:   st_nxt = (k_r == '0) ? bvpd_pkg::ST_OUT_RD : bvpd_pkg::ST_BT_WAIT;
      bvpd_pkg::ST_BT_WAIT: st_nxt = bvpd_pkg::ST_BT_RD;
      bvpd_pkg::ST_OUT_RD:  st_nxt = bvpd_pkg::ST_OUT_LD;
      bvpd_pkg::ST_OUT_LD: begin
        if (out_load) st_nxt = (k_r == lastrow_r) ? bvpd_pkg::ST_IDLE : bvpd_pkg::ST_OUT_RD;
      end
      default: st_nxt = bvpd_pkg::ST_IDLE;
    endcase
  end

  // memory and handshake controls
  always_comb begin
    in_chan.ready = 1'b0;
    s_we    = 1'b0;
    s_waddr = {bank_r, col_r};
    s_wdata = score;
    s_re    = 1'b0;
    s_raddr = {~bank_r, BW'(int'(col_r) + HALF_BAND_MAX + 1)};
    b_we    = 1'b0;
    b_waddr = BPA_W'(int'(row_r) * BINS_MAX + int'(col_r));
    b_wdata = (row_r == '0) ? col_r : best_col_r;
    b_re    = 1'b0;
    b_raddr = BPA_W'(int'(k_r) * BINS_MAX + int'(bt_b_r));
    unique case (st_r)
      bvpd_pkg::ST_IDLE: begin
        in_chan.ready = 1'b1;
        s_re          = in_fire;
      end
      bvpd_pkg::ST_WRITE: begin
        s_we = 1'b1;
        b_we = 1'b1;
      end
      bvpd_pkg::ST_PRE: begin
        s_re    = int'(pj_r) <= HALF_BAND_MAX;
        s_raddr = {~bank_r, BW'(pj_r)};
      end
      bvpd_pkg::ST_BT_RD: begin
        b_we    = 1'b1;
        b_waddr = BPA_W'(int'(k_r) * BINS_MAX);
        b_wdata = bt_b_r;
        b_re    = (k_r != '0);
      end
      bvpd_pkg::ST_OUT_RD: begin
        b_re    = 1'b1;
        b_raddr = BPA_W'(int'(k_r) * BINS_MAX);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= bvpd_pkg::ST_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      bank_r      <= 1'b0;
      pj_r        <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_load || (out_valid_r && !out_fire);
      unique case (st_r)
        bvpd_pkg::ST_WRITE: begin
          if (map_done) begin
            col_r     <= '0;
            row_r     <= '0;
            k_r       <= row_r;
          end else if (row_done) begin
            col_r  <= '0;
            row_r  <= row_r + RW'(1);
            bank_r <= ~bank_r;
            pj_r   <= '0;
          end else begin
            col_r <= col_r + BW'(1);
          end
        end
        bvpd_pkg::ST_PRE:     pj_r <= pj_r + PJW'(1);
        bvpd_pkg::ST_BT_WAIT: k_r  <= k_r - RW'(1);
        bvpd_pkg::ST_OUT_LD: begin
          if (out_load) k_r <= k_r + RW'(1);
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      em_r  <= EM_ROM[in_chan.cell_prob];
      end_r <= in_chan.map_end;
    end
    if (st_r == bvpd_pkg::ST_CALC) begin
      best_r     <= best_v;
      best_col_r <= best_c;
      nxt_r      <= s_rdata;
    end
    if (st_r == bvpd_pkg::ST_WRITE) begin
      if (score_better) begin
        run_best_r <= score;
        run_col_r  <= col_r;
      end
      for (int k = 0; k < WIN - 1; k++) win_r[k] <= win_r[k + 1];
      win_r[WIN - 1] <= nxt_r;
      if (map_done) begin
        bt_b_r    <= final_b;
        lastrow_r <= row_r;
      end
    end
    if (st_r == bvpd_pkg::ST_PRE && pj_r != '0) begin
      win_r[HALF_BAND_MAX + int'(pj_r) - 1] <= s_rdata;
    end
    if (st_r == bvpd_pkg::ST_BT_WAIT) bt_b_r <= b_rdata;
    if (out_load) begin
      out_bin_r  <= bvpd_pkg::BIN_OUT_W'(b_rdata);
      out_last_r <= (k_r == lastrow_r);
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.bin_index = out_bin_r;
  assign out_chan.path_last = out_last_r;
endmodule

// File: rtl/bvpd_chk.sv
// Port-level checker for the banded Viterbi path decoder, bound to the top.
// Depends on banded_viterbi_path_decoder_macros.svh.
`include "banded_viterbi_path_decoder_macros.svh"

module bvpd_chk (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_path_last
);
  `BVPD_ASSERT_ALWAYS(a_out_idle_after_reset, clk, !rst_n |=> !out_valid, "result valid after reset")
  `BVPD_ASSERT_IMP(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped")
  `BVPD_ASSERT_IMP(a_path_blocks_in, clk, rst_n, out_valid && !out_path_last |-> !in_ready, "request taken mid path")
endmodule

bind banded_viterbi_path_decoder bvpd_chk u_bvpd_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_path_last (out_chan.path_last)
);
